// ----- design/acs_pkg.sv -----
// Shared types and codes for the active countdown set.
// Used by acs_cell, acs_head and active_countdown_set_core; depends on nothing.
package acs_pkg;

   localparam int CODE_W  = 6;
   localparam int TIMER_W = 8;
   localparam int OCC_W   = 5;

   localparam logic [1:0] ACT_ACTIVATE   = 2'd0;
   localparam logic [1:0] ACT_DEACTIVATE = 2'd1;
   localparam logic [1:0] ACT_TICK       = 2'd2;
   localparam logic [1:0] ACT_QUERY      = 2'd3;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_ALREADY = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;

   localparam logic CSR_GLOBAL_ENABLE = 1'b0;
   localparam logic CSR_ALWAYS_MASK   = 1'b1;

   // One slot of the ring: membership bit, code and countdown.
   typedef struct packed {
      logic               valid;
      logic [CODE_W-1:0]  code;
      logic [TIMER_W-1:0] timer;
   } slot_type;

   // Control from the sequencer to the head of the ring.
   typedef struct packed {
      logic               clear;
      logic               scan;
      logic               insert;
      logic [1:0]         action;
      logic [CODE_W-1:0]  code;
      logic [TIMER_W-1:0] duration;
      logic [TIMER_W-1:0] elapsed;
   } head_ctrl_type;

   // Events and search results from the head back to the sequencer.
   typedef struct packed {
      logic               drop;
      logic               ins;
      logic               found;
      logic [TIMER_W-1:0] found_timer;
   } head_stat_type;

endpackage

// ----- design/acs_cell.sv -----
// One slot cell of the rotating ring: holds an entry and hands it on when shifting.
// Depends on acs_pkg.
module acs_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              shift_en,
   input  acs_pkg::slot_type slot_in,
   output acs_pkg::slot_type slot_out
);

   logic                        valid_ff;
   logic [acs_pkg::CODE_W-1:0]  code_ff;
   logic [acs_pkg::TIMER_W-1:0] timer_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (shift_en) begin
         valid_ff <= slot_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         code_ff  <= slot_in.code;
         timer_ff <= slot_in.timer;
      end
   end

   assign slot_out.valid = valid_ff;
   assign slot_out.code  = code_ff;
   assign slot_out.timer = timer_ff;

endmodule

// ----- design/acs_head.sv -----
// Head of the ring: edits each entry as it passes (age, drop, match, insert).
// Depends on acs_pkg.
module acs_head (
   input  logic                   clock,
   input  logic                   reset,
   input  acs_pkg::head_ctrl_type ctrl,
   input  acs_pkg::slot_type      slot_in,
   output acs_pkg::slot_type      slot_out,
   output acs_pkg::head_stat_type stat
);

   logic                        found_ff;
   logic                        found_in;
   logic [acs_pkg::TIMER_W-1:0] timer_ff;
   logic [acs_pkg::TIMER_W-1:0] timer_in;
   logic                        match;

   assign match = ctrl.scan && slot_in.valid && (slot_in.code == ctrl.code);

   always_comb begin
      slot_out         = slot_in;
      stat.drop        = 1'b0;
      stat.ins         = 1'b0;
      stat.found       = found_ff | match;
      stat.found_timer = timer_ff;
      if (ctrl.scan && slot_in.valid) begin
         case (ctrl.action)
            acs_pkg::ACT_TICK: begin
               // drop expired entries, age the rest
               if (ctrl.elapsed >= slot_in.timer) begin
                  slot_out.valid = 1'b0;
                  stat.drop      = 1'b1;
               end else begin
                  slot_out.timer = slot_in.timer - ctrl.elapsed;
               end
            end
            acs_pkg::ACT_DEACTIVATE: begin
               if (match) begin
                  slot_out.valid = 1'b0;
                  stat.drop      = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
      if (ctrl.insert && !slot_in.valid) begin
         slot_out.valid = 1'b1;
         slot_out.code  = ctrl.code;
         slot_out.timer = ctrl.duration;
         stat.ins       = 1'b1;
      end
   end

   always_comb begin
      found_in = found_ff;
      timer_in = timer_ff;
      if (ctrl.clear) begin
         found_in = 1'b0;
      end else if (match) begin
         found_in = 1'b1;
         timer_in = slot_in.timer;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      timer_ff <= timer_in;
   end

endmodule

// ----- design/active_countdown_set_core.sv -----
// Active countdown set: top level with sequencer, slot ring and result register.
// Depends on acs_pkg, acs_cell and acs_head.
//
// Usage:
//   req_* carries one operation word (activate, deactivate, tick, query);
//   rsp_* returns exactly one result word per request; csr_* writes the
//   global enable (index 0) and the always-active mask (index 1); the user
//   writes them only while the block is idle, which the block itself does
//   not enforce. csr_ready is always high. The entries live in a ring of
//   SLOTS cells that rotates one place per cycle during the scan and insert
//   passes, through a head stage; each entry meets the head once per pass.
// Sequence:
//   A request is taken in IDLE, then one pass scans the ring, then DONE
//   loads the result register. An activate of a new code adds a second,
//   partial pass that stops at the first empty cell. A new request is taken
//   only once the previous one has loaded its result and returned to IDLE.
// Reset: all cells empty, occupancy zero, both configuration registers zero.
// Stall: a finished result waits in the result register; the next request
//   is accepted and scanned meanwhile and holds in DONE until the register
//   frees up.
module active_countdown_set_core #(
   parameter int SLOTS = 16,
   parameter int CODES = 64
) (
   input  logic                        clock,
   input  logic                        reset,

   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [1:0]                  req_action,
   input  logic [acs_pkg::CODE_W-1:0]  req_code,
   input  logic [acs_pkg::TIMER_W-1:0] req_duration,
   input  logic [acs_pkg::TIMER_W-1:0] req_elapsed,

   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [1:0]                  rsp_status,
   output logic                        rsp_is_active,
   output logic [acs_pkg::TIMER_W-1:0] rsp_remaining,
   output logic [acs_pkg::OCC_W-1:0]   rsp_occupied,

   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic                        csr_index,
   input  logic [63:0]                 csr_data
);

   localparam int STEP_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W  = $clog2(SLOTS + 1);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_SCAN   = 4'b0010,
      S_INSERT = 4'b0100,
      S_DONE   = 4'b1000
   } state_type;

   state_type                   state_ff, state_in;
   logic [STEP_W-1:0]           step_ff, step_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic                        added_ff, added_in;
   logic                        load_rsp;

   logic [1:0]                  act_ff;
   logic [acs_pkg::CODE_W-1:0]  code_ff;
   logic [acs_pkg::TIMER_W-1:0] duration_ff;
   logic [acs_pkg::TIMER_W-1:0] elapsed_ff;

   logic                        enable_ff;
   logic [63:0]                 mask_ff;

   logic                        rsp_valid_ff;
   logic [1:0]                  rsp_status_ff, rsp_status_in;
   logic                        rsp_active_ff, rsp_active_in;
   logic [acs_pkg::TIMER_W-1:0] rsp_remaining_ff, rsp_remaining_in;
   logic [acs_pkg::OCC_W-1:0]   rsp_occupied_ff;

   acs_pkg::slot_type           chain [SLOTS];
   acs_pkg::slot_type           head_out;
   acs_pkg::head_ctrl_type      head_ctrl;
   acs_pkg::head_stat_type      head_stat;
   logic                        shift_en;
   logic                        in_range;
   logic                        gate;

   // ---------------- ring of slot cells ----------------
   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      if (i == 0) begin : g_first
         acs_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift_en (shift_en),
            .slot_in  (head_out),
            .slot_out (chain[i])
         );
      end else begin : g_next
         acs_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift_en (shift_en),
            .slot_in  (chain[i-1]),
            .slot_out (chain[i])
         );
      end
   end

   acs_head u_head (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (head_ctrl),
      .slot_in  (chain[SLOTS-1]),
      .slot_out (head_out),
      .stat     (head_stat)
   );

   // rotate during both passes; the partial pass stops after its insert
   assign shift_en = (state_ff == S_SCAN) || (state_ff == S_INSERT);

   assign head_ctrl.clear    = (state_ff == S_IDLE);
   assign head_ctrl.scan     = (state_ff == S_SCAN);
   assign head_ctrl.insert   = (state_ff == S_INSERT);
   assign head_ctrl.action   = act_ff;
   assign head_ctrl.code     = code_ff;
   assign head_ctrl.duration = duration_ff;
   assign head_ctrl.elapsed  = elapsed_ff;

   // codes at or above CODES never become members
   assign in_range = (32'(code_ff) < CODES);
   assign gate     = enable_ff | mask_ff[code_ff];

   // ---------------- sequencer ----------------
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      count_in = count_ff;
      added_in = added_ff;
      load_rsp = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_SCAN;
               step_in  = '0;
               added_in = 1'b0;
            end
         end
         S_SCAN: begin
            if (head_stat.drop) begin
               count_in = count_ff - CNT_W'(1);
            end
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(SLOTS - 1)) begin
               // a full pass is done: append a new code if there is room
               if ((act_ff == acs_pkg::ACT_ACTIVATE) && in_range && !head_stat.found
                   && (count_ff < CNT_W'(SLOTS))) begin
                  state_in = S_INSERT;
                  added_in = 1'b1;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_INSERT: begin
            if (head_stat.ins) begin
               count_in = count_ff + CNT_W'(1);
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // hold until the result register is free
            if (!rsp_valid_ff || rsp_ready) begin
               load_rsp = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff  <= step_in;
      added_ff <= added_in;
   end

   // latch the request word on accept
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         act_ff      <= req_action;
         code_ff     <= req_code;
         duration_ff <= req_duration;
         elapsed_ff  <= req_elapsed;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   // ---------------- configuration ----------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         mask_ff   <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            acs_pkg::CSR_GLOBAL_ENABLE: enable_ff <= csr_data[0];
            acs_pkg::CSR_ALWAYS_MASK:   mask_ff   <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // ---------------- result word ----------------
   always_comb begin
      rsp_status_in    = acs_pkg::ST_OK;
      rsp_active_in    = 1'b0;
      rsp_remaining_in = '0;
      case (act_ff)
         acs_pkg::ACT_ACTIVATE: begin
            if (!in_range) begin
               rsp_status_in = acs_pkg::ST_FULL;
            end else if (head_stat.found) begin
               rsp_status_in    = acs_pkg::ST_ALREADY;
               rsp_active_in    = gate;
               rsp_remaining_in = head_stat.found_timer;
            end else if (added_ff) begin
               rsp_active_in    = gate;
               rsp_remaining_in = duration_ff;
            end else begin
               rsp_status_in = acs_pkg::ST_FULL;
            end
         end
         acs_pkg::ACT_QUERY: begin
            if (head_stat.found) begin
               rsp_active_in    = gate;
               rsp_remaining_in = head_stat.found_timer;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_status_ff    <= rsp_status_in;
         rsp_active_ff    <= rsp_active_in;
         rsp_remaining_ff <= rsp_remaining_in;
         rsp_occupied_ff  <= acs_pkg::OCC_W'(count_ff);
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_is_active = rsp_active_ff;
   assign rsp_remaining = rsp_remaining_ff;
   assign rsp_occupied  = rsp_occupied_ff;

   // ---------------- assertions ----------------
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(SLOTS))
      else $error("occupancy exceeds slot count");

   a_insert_only_new: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_INSERT) |-> (act_ff == acs_pkg::ACT_ACTIVATE) && !head_stat.found)
      else $error("insert pass for a non-activate or a present code");

   a_insert_no_drop: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_INSERT) |-> !head_stat.drop)
      else $error("entry dropped during insert pass");

   a_done_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) && !rsp_valid_ff |=> rsp_valid_ff && (state_ff == S_IDLE))
      else $error("finished word not loaded into result register");

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for active_countdown_set_core: directed and random
// activate/deactivate/tick/query words checked against a predictor class.
// Depends on acs_pkg and the RTL of active_countdown_set_core.
`timescale 1ns / 1ps

module testbench;

   localparam int SLOTS       = 16;
   localparam int CODES       = 64;
   localparam int PHASE_WORDS = 158;
   localparam int SETTLE_WAIT = 2 * SLOTS + 8;
   localparam int CYCLE_LIMIT = 500_000;

   // One result word as the block returns it.
   typedef struct packed {
      logic [1:0]                  status;
      logic                        is_active;
      logic [acs_pkg::TIMER_W-1:0] remaining;
      logic [acs_pkg::OCC_W-1:0]   occupied;
   } answer_type;

   // Predictor of the countdown set plus the queue of answers still owed.
   class countdown_scoreboard;
      bit [acs_pkg::CODE_W-1:0]  slot_code    [SLOTS];
      bit [acs_pkg::TIMER_W-1:0] slot_timer   [SLOTS];
      bit [acs_pkg::OCC_W-1:0]   slot_of_code [CODES];
      bit                        code_listed  [CODES];
      int unsigned               occupancy;
      bit                        enable_all;
      bit [63:0]                 keep_mask;
      answer_type                pending_answers[$];
      int                        errors;
      int                        checked;
      int                        action_seen[4];
      int                        full_seen;
      int                        dup_seen;

      function void write_register(logic index, logic [63:0] data);
         if (index == acs_pkg::CSR_GLOBAL_ENABLE) begin
            enable_all = data[0];
         end else begin
            keep_mask = data;
         end
      endfunction

      function bit holds(bit [acs_pkg::CODE_W-1:0] c);
         return code_listed[c] && slot_of_code[c] < occupancy;
      endfunction

      // Free slot s and move the last occupied slot into the hole.
      function void vacate(int unsigned s);
         bit [acs_pkg::CODE_W-1:0] moved;
         code_listed[slot_code[s]] = 1'b0;
         occupancy--;
         if (s < occupancy) begin
            slot_code[s]  = slot_code[occupancy];
            slot_timer[s] = slot_timer[occupancy];
            moved = slot_code[s];
            slot_of_code[moved] = s[acs_pkg::OCC_W-1:0];
            code_listed[moved]  = 1'b1;
         end
      endfunction

      function void note_request(logic [1:0] action, logic [acs_pkg::CODE_W-1:0] code,
                                 logic [acs_pkg::TIMER_W-1:0] duration,
                                 logic [acs_pkg::TIMER_W-1:0] elapsed);
         answer_type  ans;
         int unsigned s;
         ans = '0;
         case (action)
            acs_pkg::ACT_ACTIVATE: begin
               if (holds(code)) begin
                  ans.status = acs_pkg::ST_ALREADY;
               end else if (occupancy < SLOTS) begin
                  slot_code[occupancy]  = code;
                  slot_timer[occupancy] = duration;
                  slot_of_code[code] = occupancy[acs_pkg::OCC_W-1:0];
                  code_listed[code]  = 1'b1;
                  occupancy++;
               end else begin
                  ans.status = acs_pkg::ST_FULL;
               end
            end
            acs_pkg::ACT_DEACTIVATE: begin
               if (holds(code)) vacate(slot_of_code[code]);
            end
            acs_pkg::ACT_TICK: begin
               s = 0;
               while (s < occupancy) begin
                  if (elapsed >= slot_timer[s]) begin
                     vacate(s);
                  end else begin
                     slot_timer[s] = slot_timer[s] - elapsed;
                     s++;
                  end
               end
            end
            default: ;
         endcase
         if (action != acs_pkg::ACT_TICK && holds(code)) begin
            ans.remaining = slot_timer[slot_of_code[code]];
            ans.is_active = enable_all | keep_mask[code];
         end
         ans.occupied = occupancy[acs_pkg::OCC_W-1:0];
         action_seen[action]++;
         if (ans.status == acs_pkg::ST_FULL) full_seen++;
         if (ans.status == acs_pkg::ST_ALREADY) dup_seen++;
         pending_answers.push_back(ans);
      endfunction

      function void check_answer(answer_type got);
         answer_type want;
         if (pending_answers.size() == 0) begin
            $error("result word with nothing outstanding: %h", got);
            errors++;
            return;
         end
         want = pending_answers.pop_front();
         checked++;
         if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errors++;
         end
         if (got.is_active !== want.is_active) begin
            $error("is_active: expected %0d, got %0d", want.is_active, got.is_active);
            errors++;
         end
         if (got.remaining !== want.remaining) begin
            $error("remaining: expected %0d, got %0d", want.remaining, got.remaining);
            errors++;
         end
         if (got.occupied !== want.occupied) begin
            $error("occupied: expected %0d, got %0d", want.occupied, got.occupied);
            errors++;
         end
      endfunction
   endclass

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_ready;
   logic [1:0]                  req_action;
   logic [acs_pkg::CODE_W-1:0]  req_code;
   logic [acs_pkg::TIMER_W-1:0] req_duration;
   logic [acs_pkg::TIMER_W-1:0] req_elapsed;
   logic                        rsp_valid;
   logic                        rsp_ready;
   logic [1:0]                  rsp_status;
   logic                        rsp_is_active;
   logic [acs_pkg::TIMER_W-1:0] rsp_remaining;
   logic [acs_pkg::OCC_W-1:0]   rsp_occupied;
   logic                        csr_valid;
   logic                        csr_ready;
   logic                        csr_index;
   logic [63:0]                 csr_data;

   countdown_scoreboard board;
   int                  cycle_count;
   logic [7:0]          stall_pattern;
   int                  pattern_age;

   active_countdown_set_core #(
      .SLOTS (SLOTS),
      .CODES (CODES)
   ) u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_action    (req_action),
      .req_code      (req_code),
      .req_duration  (req_duration),
      .req_elapsed   (req_elapsed),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_is_active (rsp_is_active),
      .rsp_remaining (rsp_remaining),
      .rsp_occupied  (rsp_occupied),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Stop a hung run: far above the slowest legal run of all phases.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Receiver: ready follows a rotating 8-bit pattern, replaced when a random
   // age counter runs out. An all-ones pattern gives stretches with no stall,
   // a sparse one keeps the result register stalled on most cycles.
   // Results are sampled at the edge, so check with the pre-edge values.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         board.check_answer({rsp_status, rsp_is_active, rsp_remaining, rsp_occupied});
      end
      rsp_ready <= stall_pattern[0];
      if (pattern_age == 0) begin
         stall_pattern <= ($urandom_range(0, 3) == 0) ? 8'hff : 8'($urandom_range(1, 255));
         pattern_age   <= $urandom_range(50, 300);
      end else begin
         stall_pattern <= {stall_pattern[0], stall_pattern[7:1]};
         pattern_age   <= pattern_age - 1;
      end
   end

   // Present one request word and hold it until the block takes it. Valid
   // stays high on return so a burst can follow in the same step.
   task automatic send_word(input logic [1:0] action,
                            input logic [acs_pkg::CODE_W-1:0] code,
                            input logic [acs_pkg::TIMER_W-1:0] duration,
                            input logic [acs_pkg::TIMER_W-1:0] elapsed);
      req_valid    <= 1'b1;
      req_action   <= action;
      req_code     <= code;
      req_duration <= duration;
      req_elapsed  <= elapsed;
      do @(posedge clock); while (!req_ready);
      board.note_request(action, code, duration, elapsed);
   endtask

   // Write one register; only called while the block is idle.
   task automatic write_register(input logic index, input logic [63:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      board.write_register(index, data);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Drop valid, wait for every owed result word, then let the ring finish
   // its pass before anything touches the registers.
   task automatic settle();
      req_valid <= 1'b0;
      while (board.pending_answers.size() != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   // Random words in bursts with random gaps. Codes lean toward a small pool
   // so duplicates, hits on deactivate and a full table come up often; ticks
   // mostly subtract a little so entries live across many words.
   task automatic run_random(input int count);
      int                          burst_left;
      int                          gap;
      int                          roll;
      logic [1:0]                  action;
      logic [acs_pkg::CODE_W-1:0]  code;
      logic [acs_pkg::TIMER_W-1:0] duration;
      logic [acs_pkg::TIMER_W-1:0] elapsed;
      burst_left = 0;
      for (int i = 0; i < count; i++) begin
         if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? 40 : $urandom_range(1, 12);
         end
         roll = $urandom_range(0, 99);
         if (roll < 40)      action = acs_pkg::ACT_ACTIVATE;
         else if (roll < 60) action = acs_pkg::ACT_DEACTIVATE;
         else if (roll < 72) action = acs_pkg::ACT_TICK;
         else                action = acs_pkg::ACT_QUERY;
         code = ($urandom_range(0, 9) < 6) ? 6'($urandom_range(0, 19))
                                           : 6'($urandom_range(0, 63));
         roll = $urandom_range(0, 9);
         if (roll == 0)     duration = '0;
         else if (roll < 7) duration = 8'($urandom_range(16, 255));
         else               duration = 8'($urandom_range(0, 255));
         roll = $urandom_range(0, 9);
         if (roll < 7)      elapsed = 8'($urandom_range(0, 6));
         else if (roll < 9) elapsed = 8'($urandom_range(7, 40));
         else               elapsed = 8'($urandom_range(0, 255));
         send_word(action, code, duration, elapsed);
         burst_left--;
      end
   endtask

   initial begin
      logic        enable_value;
      logic [63:0] mask_value;
      clock         = 1'b0;
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_action    <= acs_pkg::ACT_QUERY;
      req_code      <= '0;
      req_duration  <= '0;
      req_elapsed   <= '0;
      rsp_ready     <= 1'b1;
      csr_valid     <= 1'b0;
      csr_index     <= acs_pkg::CSR_GLOBAL_ENABLE;
      csr_data      <= '0;
      cycle_count   <= 0;
      stall_pattern <= 8'hff;
      pattern_age   <= 100;
      board = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: only the top and bottom codes are forced active.
      write_register(acs_pkg::CSR_GLOBAL_ENABLE, 64'd0);
      write_register(acs_pkg::CSR_ALWAYS_MASK, 64'h8000_0000_0000_0001);
      send_word(acs_pkg::ACT_ACTIVATE, 6'd0, 8'd255, 8'd0);
      // zero duration: stored, gone at the next tick even with nothing elapsed
      send_word(acs_pkg::ACT_ACTIVATE, 6'd63, 8'd0, 8'd255);
      // duplicate: status already active, timer untouched
      send_word(acs_pkg::ACT_ACTIVATE, 6'd0, 8'd7, 8'd0);
      send_word(acs_pkg::ACT_QUERY, 6'd63, 8'd0, 8'd0);
      send_word(acs_pkg::ACT_TICK, 6'd0, 8'd0, 8'd0);
      send_word(acs_pkg::ACT_QUERY, 6'd0, 8'd0, 8'd0);
      // deactivate of an absent code is ignored
      send_word(acs_pkg::ACT_DEACTIVATE, 6'd63, 8'd0, 8'd0);
      send_word(acs_pkg::ACT_DEACTIVATE, 6'd0, 8'd0, 8'd0);
      // fill every slot, then one more for the full case
      for (int i = 0; i < SLOTS; i++) begin
         send_word(acs_pkg::ACT_ACTIVATE, 6'(2 * i + 1), 8'(i * 17), 8'd0);
      end
      send_word(acs_pkg::ACT_ACTIVATE, 6'd40, 8'd9, 8'd0);
      // the largest elapsed value empties the table
      send_word(acs_pkg::ACT_TICK, 6'd63, 8'd255, 8'd255);
      settle();

      // Random phases, each under its own gating setting.
      for (int phase = 1; phase <= 6; phase++) begin
         case (phase)
            1: begin enable_value = 1'b1; mask_value = '0; end
            2: begin enable_value = 1'b0; mask_value = '1; end
            4: begin enable_value = 1'b1; mask_value = '1; end
            5: begin enable_value = 1'b0; mask_value = '0; end
            default: begin
               enable_value = 1'b0;
               mask_value   = {$urandom, $urandom};
            end
         endcase
         write_register(acs_pkg::CSR_GLOBAL_ENABLE, {63'd0, enable_value});
         write_register(acs_pkg::CSR_ALWAYS_MASK, mask_value);
         run_random(PHASE_WORDS);
         settle();
      end

      $display("covered %0d activates, %0d deactivates, %0d ticks, %0d queries",
               board.action_seen[acs_pkg::ACT_ACTIVATE],
               board.action_seen[acs_pkg::ACT_DEACTIVATE],
               board.action_seen[acs_pkg::ACT_TICK],
               board.action_seen[acs_pkg::ACT_QUERY]);
      $display("%0d result words checked, %0d table-full and %0d duplicate activates",
               board.checked, board.full_seen, board.dup_seen);
      if (board.errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
design/acs_pkg.sv
design/acs_cell.sv
design/acs_head.sv
design/active_countdown_set_core.sv
tb/sv/testbench.sv
